@@ rtl/dcmc_pkg.sv @@
// ----------------------------------------------------------------------------
// dcmc_pkg: shared types and constants
// Controller states and the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package dcmc_pkg;

    localparam int unsigned IDX_W     = 20;
    localparam logic [9:0]  THRESH_RST = 10'd500;
    localparam logic [9:0]  NEAR_DIST  = 10'd10;

    localparam logic [1:0] REG_FIRST  = 2'd0;
    localparam logic [1:0] REG_SECOND = 2'd1;
    localparam logic [1:0] REG_THRESH = 2'd2;
    localparam logic [1:0] REG_WIDTH  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic load;
        logic probe;
        logic write;
    } cmd_t;

    typedef struct packed {
        logic probe_done;
    } stat_t;

endpackage

@@ rtl/dcmc_ctrl.sv @@
// ----------------------------------------------------------------------------
// dcmc_ctrl: request sequencer
// Loads a request, steps the datapath over the cross probes, writes back, presents result.
// ----------------------------------------------------------------------------
module dcmc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    output dcmc_pkg::cmd_t  cmd,
    input  dcmc_pkg::stat_t stat
);

    dcmc_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dcmc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            dcmc_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = dcmc_pkg::ST_PROBE;
                end
            end
            dcmc_pkg::ST_PROBE:
            begin
                cmd.probe = 1'b1;
                if (stat.probe_done)
                begin
                    state_next = dcmc_pkg::ST_WRITE;
                end
            end
            dcmc_pkg::ST_WRITE:
            begin
                // wait here while the output register still holds a stalled result
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.write      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = dcmc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dcmc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/dcmc_datapath.sv @@
// ----------------------------------------------------------------------------
// dcmc_datapath: distance compare, flag ring and cross probe
// One ring read per probe; probes go back k and k*width for each reach step.
// ----------------------------------------------------------------------------
module dcmc_datapath #(
    parameter int unsigned MAX_WIDTH   = 1024,
    parameter int unsigned CROSS_REACH = 5
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_en,
    input  logic [1:0]      cfg_index,
    input  logic [23:0]     cfg_data,
    input  logic [7:0]      pixel_red,
    input  logic [7:0]      pixel_green,
    input  logic [7:0]      pixel_blue,
    input  logic            last_pixel,
    input  dcmc_pkg::cmd_t  cmd,
    output dcmc_pkg::stat_t stat,
    output logic            mask_set,
    output logic            frame_done,
    output logic            target_near
);

    localparam int unsigned RING_DEPTH = 2 * (CROSS_REACH - 1) * (MAX_WIDTH + 1) + 1;
    localparam int unsigned RA_W  = $clog2(RING_DEPTH);
    localparam int unsigned LW_W  = $clog2(MAX_WIDTH + 1);
    localparam int unsigned K_W   = $clog2(CROSS_REACH + 1);
    localparam int unsigned IDX_W = dcmc_pkg::IDX_W;
    localparam int unsigned BK_W  = LW_W + K_W;
    localparam int unsigned NPROBE = 2 * (CROSS_REACH - 1);
    localparam int unsigned PC_W  = $clog2(NPROBE + 2);

    logic [23:0] first_reg, second_reg;
    logic [9:0]  thresh_reg;
    logic [10:0] width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= '0;
            second_reg <= '0;
            thresh_reg <= dcmc_pkg::THRESH_RST;
            width_reg  <= 11'd1024;
        end
        else if (cfg_en)
        begin
            case (cfg_index)
                dcmc_pkg::REG_FIRST:  first_reg  <= cfg_data;
                dcmc_pkg::REG_SECOND: second_reg <= cfg_data;
                dcmc_pkg::REG_THRESH: thresh_reg <= cfg_data[9:0];
                dcmc_pkg::REG_WIDTH:  width_reg  <= cfg_data[10:0];
                default:              ;
            endcase
        end
    end

    // clamped width
    logic [LW_W-1:0] w_eff;
    always_comb
    begin
        if (width_reg == 11'd0)
        begin
            w_eff = LW_W'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_eff = LW_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = LW_W'(width_reg);
        end
    end

    function automatic logic [9:0] l1_dist(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b, input logic [23:0] t);
        logic [7:0] dr, dg, db;
        begin
            dr = (r > t[23:16]) ? r - t[23:16] : t[23:16] - r;
            dg = (g > t[15:8])  ? g - t[15:8]  : t[15:8] - g;
            db = (b > t[7:0])   ? b - t[7:0]   : t[7:0] - b;
            l1_dist = 10'(dr) + 10'(dg) + 10'(db);
        end
    endfunction

    logic [9:0] d0, d1;
    logic first_hit, second_only, near;
    assign d0 = l1_dist(pixel_red, pixel_green, pixel_blue, first_reg);
    assign d1 = l1_dist(pixel_red, pixel_green, pixel_blue, second_reg);
    assign first_hit   = d0 < thresh_reg;
    assign second_only = !first_hit && (d1 < thresh_reg);
    assign near        = d0 < dcmc_pkg::NEAR_DIST;

    logic            mask_reg, last_reg, so_reg, near_reg;
    logic [IDX_W-1:0] p_reg;
    logic [RA_W-1:0]  pr_reg;      // p mod RING_DEPTH
    logic            found_reg, found_next;
    logic [PC_W-1:0] pc_reg;
    logic [K_W-1:0]  k_reg;
    logic [BK_W-1:0] kw_reg;
    logic            rd_pend_reg, rd_ok_reg;
    logic [1:0]      ring_q;
    logic [1:0]      ring_mem [RING_DEPTH];

    // probe address for current step
    logic [BK_W-1:0] back;
    logic            ok;
    logic [RA_W:0]   addr_w;
    logic [RA_W-1:0] raddr;
    assign back  = pc_reg[0] ? kw_reg : BK_W'(k_reg);
    assign ok    = 32'(back) <= 32'(p_reg);
    assign addr_w = ({1'b0, pr_reg} >= (RA_W+1)'(back)) ?
                    {1'b0, pr_reg} - (RA_W+1)'(back) :
                    {1'b0, pr_reg} + (RA_W+1)'(RING_DEPTH) - (RA_W+1)'(back);
    assign raddr = addr_w[RA_W-1:0];

    logic probing;
    assign probing = cmd.probe && (32'(pc_reg) < NPROBE);
    assign stat.probe_done = cmd.probe && (32'(pc_reg) == NPROBE) && !rd_pend_reg;

    always_ff @(posedge clk)
    begin
        if (probing)
        begin
            ring_q <= ring_mem[raddr];
        end
        if (cmd.write)
        begin
            ring_mem[pr_reg] <= {so_reg, near_reg};
        end
    end

    always_comb
    begin
        found_next = found_reg;
        if (rd_pend_reg && rd_ok_reg)
        begin
            if ((so_reg && ring_q[0]) || (near_reg && ring_q[1]))
            begin
                found_next = 1'b1;
            end
        end
        if (cmd.load && second_only && near)
        begin
            found_next = 1'b1;
        end
        if (cmd.write && last_reg)
        begin
            found_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg       <= '0;
            pr_reg      <= '0;
            found_reg   <= 1'b0;
            pc_reg      <= '0;
            k_reg       <= '0;
            kw_reg      <= '0;
            rd_pend_reg <= 1'b0;
            rd_ok_reg   <= 1'b0;
        end
        else
        begin
            found_reg   <= found_next;
            rd_pend_reg <= probing;
            rd_ok_reg   <= ok;
            if (cmd.load)
            begin
                pc_reg <= '0;
                k_reg  <= K_W'(1);
                kw_reg <= BK_W'(w_eff);
            end
            else if (probing)
            begin
                pc_reg <= pc_reg + PC_W'(1);
                if (pc_reg[0])
                begin
                    k_reg  <= k_reg + K_W'(1);
                    kw_reg <= kw_reg + BK_W'(w_eff);
                end
            end
            if (cmd.write)
            begin
                if (last_reg)
                begin
                    p_reg  <= '0;
                    pr_reg <= '0;
                end
                else
                begin
                    p_reg <= p_reg + IDX_W'(1);
                    if (p_reg == '1)
                    begin
                        pr_reg <= '0;
                    end
                    else if (32'(pr_reg) == RING_DEPTH - 1)
                    begin
                        pr_reg <= '0;
                    end
                    else
                    begin
                        pr_reg <= pr_reg + RA_W'(1);
                    end
                end
            end
        end
    end

    logic mask_out_reg, done_out_reg, near_out_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mask_reg <= first_hit || second_only;
            last_reg <= last_pixel;
            so_reg   <= second_only;
            near_reg <= near;
        end
        if (cmd.write)
        begin
            mask_out_reg <= mask_reg;
            done_out_reg <= last_reg;
            near_out_reg <= last_reg && found_reg;
        end
    end

    assign mask_set    = mask_out_reg;
    assign frame_done  = done_out_reg;
    assign target_near = near_out_reg;

endmodule

@@ rtl/dual_color_mask_cross_check_unit.sv @@
// ----------------------------------------------------------------------------
// dual_color_mask_cross_check_unit: two-color pixel mask with cross check
// Masks pixels by L1 distance and flags second-color pixels near first-color ones.
// ----------------------------------------------------------------------------
// channel | direction | fields
// pixel   | in        | pixel_red, pixel_green, pixel_blue, last_pixel
// result  | out       | mask_set, frame_done, target_near
// config  | in        | cfg_en, cfg_index, cfg_data
//
// Each request is paced by the single read port of the flag ring, one probe a
// cycle; the next request is taken only after the current one is written back.
// The ring needs no clearing: only positions written this frame are used.
// One output register holds a finished result; while it stays stalled the next
// request waits in its write step and the pixel input stays stalled.
// ----------------------------------------------------------------------------
module dual_color_mask_cross_check_unit #(
    parameter int unsigned MAX_WIDTH   = 1024,
    parameter int unsigned CROSS_REACH = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_en,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  pixel_red,
    input  logic [7:0]  pixel_green,
    input  logic [7:0]  pixel_blue,
    input  logic        last_pixel,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        mask_set,
    output logic        frame_done,
    output logic        target_near
);

    dcmc_pkg::cmd_t  cmd;
    dcmc_pkg::stat_t stat;

    dcmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    dcmc_datapath #(
        .MAX_WIDTH   (MAX_WIDTH),
        .CROSS_REACH (CROSS_REACH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_en      (cfg_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_red   (pixel_red),
        .pixel_green (pixel_green),
        .pixel_blue  (pixel_blue),
        .last_pixel  (last_pixel),
        .cmd         (cmd),
        .stat        (stat),
        .mask_set    (mask_set),
        .frame_done  (frame_done),
        .target_near (target_near)
    );

endmodule
